/* design/pds_pkg.sv */
`default_nettype none

package pds_pkg;

  // Register file layout
  localparam int CFG_W     = 11;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_DEST_WIDTH    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DEST_HEIGHT   = 3'd3;

  localparam logic [CFG_W-1:0] SOURCE_WIDTH_RESET  = 11'd320;
  localparam logic [CFG_W-1:0] SOURCE_HEIGHT_RESET = 11'd200;
  localparam logic [CFG_W-1:0] DEST_WIDTH_RESET    = 11'd176;
  localparam logic [CFG_W-1:0] DEST_HEIGHT_RESET   = 11'd144;

  // Item operations
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [7:0]  color_index;
    logic [23:0] entry_rgb;
  } item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [9:0] out_x;
    logic [9:0] out_y;
    logic       frame_end;
  } result_t;

  typedef struct packed {
    logic [REG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;
  } cfg_write_t;

  // Palette access issued with an accepted item
  typedef struct packed {
    logic        wr;
    logic        rd;
    logic [7:0]  index;
    logic [23:0] rgb;
  } pal_req_t;

endpackage

`default_nettype wire

/* design/pds_chan_if.sv */
`default_nettype none

interface pds_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* design/pds_palette.sv */
`default_nettype none

module pds_palette #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire pds_pkg::pal_req_t req,
  output logic [23:0]           color
);

  localparam int IW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  logic [23:0]          mem [PALETTE_ENTRIES];
  logic [PALETTE_ENTRIES-1:0] written;
  logic [IW-1:0]        addr;
  logic                 in_range;
  logic [23:0]          rdata;
  logic                 written_q;
  logic                 in_range_q;
  logic [7:0]           index_q;

  assign addr     = req.index[IW-1:0];
  assign in_range = (req.index < PALETTE_ENTRIES);

  // Storage: one access per cycle, read data registered
  always_ff @(posedge clk) begin
    if (req.wr && in_range) begin
      mem[addr] <= req.rgb;
    end
    if (req.rd) begin
      rdata <= mem[addr];
    end
  end

  // Written marks: an unmarked entry still holds its grey ramp value
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (req.wr && in_range) begin
      written[addr] <= 1'b1;
    end
  end

  // Read side tags, held with the read data
  always_ff @(posedge clk) begin
    if (req.rd) begin
      written_q  <= written[addr];
      in_range_q <= in_range;
      index_q    <= req.index;
    end
  end

  // Out of range reads black, unwritten reads grey
  always_comb begin
    if (!in_range_q) begin
      color = '0;
    end else if (written_q) begin
      color = rdata;
    end else begin
      color = {index_q, index_q, index_q};
    end
  end

endmodule

`default_nettype wire

/* design/palette_downscale_pixel_stream_unit.sv */
// Nearest-neighbour downscaler with palette lookup on a raster pixel stream.
// items   : sink channel of pds_pkg::item_t. A pixel item carries a palette
//           index in source raster order; a write item loads one palette entry.
// results : source channel of pds_pkg::result_t, one RGB888 pixel with its
//           destination column/row and a frame_end mark for each picked pixel.
// regs    : register write channel (source/dest width and height); always
//           ready. A write to one of the four size registers restarts the
//           stream at the top of a frame; other indices are ignored.
// One item is taken per clock while items.ready is high. A picked pixel
// passes through the palette read stage and then the output register before
// it appears on results. The rate is set by the single palette port, used at
// most once per item, and by the one-add column and row stepping.
// When results stalls, the read stage and output register hold and items
// stops taking transfers only once both are full; dropped pixels and
// palette writes still need items.ready.
// Reset: registers return to 320x200 -> 176x144, counters to frame start and
// the palette to a grey ramp at once (per-entry written marks, no sweep).
`default_nettype none

module palette_downscale_pixel_stream_unit #(
  parameter int MAX_SIDE        = 1024,
  parameter int PALETTE_ENTRIES = 256
) (
  input  wire logic clk,
  input  wire logic rst,
  pds_chan_if.sink   items,
  pds_chan_if.source results,
  pds_chan_if.sink   regs
);

  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int CNT_W  = $clog2(MAX_SIDE);
  localparam int ERR_W  = SIDE_W + 1;
  localparam int CW     = pds_pkg::CFG_W;

  // Register file
  logic [CW-1:0] source_width;
  logic [CW-1:0] source_height;
  logic [CW-1:0] dest_width;
  logic [CW-1:0] dest_height;
  logic          cfg_wr;
  logic          cfg_restart;

  assign regs.ready  = 1'b1;
  assign cfg_wr      = regs.valid;
  assign cfg_restart = cfg_wr && (regs.payload.index inside {pds_pkg::REG_SOURCE_WIDTH,
                         pds_pkg::REG_SOURCE_HEIGHT, pds_pkg::REG_DEST_WIDTH,
                         pds_pkg::REG_DEST_HEIGHT});

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= pds_pkg::SOURCE_WIDTH_RESET;
      source_height <= pds_pkg::SOURCE_HEIGHT_RESET;
      dest_width    <= pds_pkg::DEST_WIDTH_RESET;
      dest_height   <= pds_pkg::DEST_HEIGHT_RESET;
    end else if (cfg_wr) begin
      case (regs.payload.index)
        pds_pkg::REG_SOURCE_WIDTH:  source_width  <= regs.payload.data;
        pds_pkg::REG_SOURCE_HEIGHT: source_height <= regs.payload.data;
        pds_pkg::REG_DEST_WIDTH:    dest_width    <= regs.payload.data;
        pds_pkg::REG_DEST_HEIGHT:   dest_height   <= regs.payload.data;
        default: ;
      endcase
    end
  end

  // Effective sizes: sources to 1..MAX_SIDE, destinations to 1..source
  logic [SIDE_W-1:0] sw, sh, dw, dh;

  always_comb begin
    if (source_width == '0) sw = SIDE_W'(1);
    else if (source_width > MAX_SIDE) sw = SIDE_W'(MAX_SIDE);
    else sw = SIDE_W'(source_width);

    if (source_height == '0) sh = SIDE_W'(1);
    else if (source_height > MAX_SIDE) sh = SIDE_W'(MAX_SIDE);
    else sh = SIDE_W'(source_height);

    if (dest_width == '0) dw = SIDE_W'(1);
    else if (dest_width > sw) dw = sw;
    else dw = SIDE_W'(dest_width);

    if (dest_height == '0) dh = SIDE_W'(1);
    else if (dest_height > sh) dh = sh;
    else dh = SIDE_W'(dest_height);
  end

  // Pipeline control
  logic s1_valid;
  logic s1_move;
  logic out_valid;
  logic accept;
  logic pixel_acc;
  logic write_acc;
  logic picked;

  assign s1_move     = !out_valid || results.ready;
  assign items.ready = !s1_valid || s1_move;
  assign accept      = items.valid && items.ready;
  assign pixel_acc   = accept && (items.payload.operation == pds_pkg::OP_PIXEL);
  assign write_acc   = accept && (items.payload.operation == pds_pkg::OP_WRITE);

  // Stream position
  logic [CNT_W-1:0]  source_column, source_row;
  logic [SIDE_W-1:0] dest_column, dest_row;
  logic [ERR_W-1:0]  column_error, row_error;

  logic              col_hit, row_hit;
  logic [ERR_W-1:0]  col_sum, col_rem, row_sum, row_rem;
  logic [SIDE_W-1:0] scol_inc, srow_inc;
  logic              line_end, frame_wrap;
  logic              last_pixel;

  always_comb begin
    col_hit  = (dest_column < dw) && (column_error < ERR_W'(dw));
    row_hit  = (dest_row < dh) && (row_error < ERR_W'(dh));
    col_sum  = column_error + (col_hit ? ERR_W'(sw) : '0);
    col_rem  = (col_sum >= ERR_W'(dw)) ? col_sum - ERR_W'(dw) : '0;
    row_sum  = row_error + (row_hit ? ERR_W'(sh) : '0);
    row_rem  = (row_sum >= ERR_W'(dh)) ? row_sum - ERR_W'(dh) : '0;
    scol_inc = SIDE_W'(source_column) + SIDE_W'(1);
    srow_inc = SIDE_W'(source_row) + SIDE_W'(1);
    line_end   = (scol_inc >= sw);
    frame_wrap = (srow_inc >= sh);
    picked     = col_hit && row_hit;
    last_pixel = (dest_column == dw - SIDE_W'(1)) && (dest_row == dh - SIDE_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_restart) begin
      source_column <= '0;
      source_row    <= '0;
      dest_column   <= '0;
      dest_row      <= '0;
      column_error  <= '0;
      row_error     <= '0;
    end else if (pixel_acc) begin
      if (line_end) begin
        source_column <= '0;
        dest_column   <= '0;
        column_error  <= '0;
        if (frame_wrap) begin
          source_row <= '0;
          dest_row   <= '0;
          row_error  <= '0;
        end else begin
          source_row <= srow_inc[CNT_W-1:0];
          dest_row   <= dest_row + SIDE_W'(row_hit);
          row_error  <= row_rem;
        end
      end else begin
        source_column <= scol_inc[CNT_W-1:0];
        dest_column   <= dest_column + SIDE_W'(col_hit);
        column_error  <= col_rem;
      end
    end
  end

  // Palette access
  pds_pkg::pal_req_t pal_req;
  logic [23:0]       pal_color;

  always_comb begin
    pal_req.wr    = write_acc;
    pal_req.rd    = pixel_acc && picked;
    pal_req.index = items.payload.color_index;
    pal_req.rgb   = items.payload.entry_rgb;
  end

  pds_palette #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_palette (
    .clk   (clk),
    .rst   (rst),
    .req   (pal_req),
    .color (pal_color)
  );

  // Read stage: coordinates travel beside the palette read
  logic [SIDE_W+9:0] x_ext, y_ext;
  logic [9:0]        s1_x, s1_y;
  logic              s1_end;

  assign x_ext = {10'b0, dest_column};
  assign y_ext = {10'b0, dest_row};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pal_req.rd) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pal_req.rd) begin
      s1_x   <= x_ext[9:0];
      s1_y   <= y_ext[9:0];
      s1_end <= last_pixel;
    end
  end

  // Output register
  pds_pkg::result_t out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_valid) begin
      out_data.red       <= pal_color[23:16];
      out_data.green     <= pal_color[15:8];
      out_data.blue      <= pal_color[7:0];
      out_data.out_x     <= s1_x;
      out_data.out_y     <= s1_y;
      out_data.frame_end <= s1_end;
    end
  end

  assign results.valid   = out_valid;
  assign results.payload = out_data;

  // Checks
  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_move |=> s1_valid && $stable(s1_x) && $stable(s1_y))
    else $error("read stage lost or changed a stalled pixel");

  a_picked_issues: assert property (@(posedge clk) disable iff (rst)
    pixel_acc && picked |=> s1_valid)
    else $error("picked pixel did not enter the read stage");

  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    (SIDE_W'(source_column) < sw) && (dest_column <= dw))
    else $error("column counters out of range");

  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    (SIDE_W'(source_row) < sh) && (dest_row <= dh))
    else $error("row counters out of range");

endmodule

`default_nettype wire

/* test/testbench.sv */
`default_nettype none

module testbench;

  localparam logic [10:0] SIDE_LIMIT = 11'd1024;
  localparam logic [pds_pkg::REG_IDX_W-1:0] REG_UNUSED = 3'd5;
  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;

  logic clk = 1'b0;
  logic rst;

  always #1 clk = ~clk;

  pds_chan_if #(.payload_t(pds_pkg::item_t))      item_ch ();
  pds_chan_if #(.payload_t(pds_pkg::result_t))    result_ch ();
  pds_chan_if #(.payload_t(pds_pkg::cfg_write_t)) reg_ch ();

  palette_downscale_pixel_stream_unit dut (
    .clk     (clk),
    .rst     (rst),
    .items   (item_ch),
    .results (result_ch),
    .regs    (reg_ch)
  );

  // Scaler state as seen from outside
  logic [23:0] palette [256];
  logic [10:0] cfg_sw, cfg_sh, cfg_dw, cfg_dh;
  logic [10:0] src_col, src_row, dst_col, dst_row;
  logic [11:0] col_rem, row_rem;

  pds_pkg::item_t   stream_items [$];
  pds_pkg::result_t expected_pixels [$];

  int errors = 0;
  int items_in = 0;
  int writes_in = 0;
  int pixels_out = 0;
  int frame_ends = 0;
  int reg_writes = 0;

  logic hold_off_req = 1'b0;

  function automatic logic [10:0] limit_side(logic [10:0] v, logic [10:0] hi);
    if (v == 11'd0) return 11'd1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void restart_stream();
    src_col = '0;
    src_row = '0;
    dst_col = '0;
    dst_row = '0;
    col_rem = '0;
    row_rem = '0;
  endfunction

  function automatic void reset_scaler();
    for (int i = 0; i < 256; i++) begin
      palette[i] = {i[7:0], i[7:0], i[7:0]};
    end
    cfg_sw = pds_pkg::SOURCE_WIDTH_RESET;
    cfg_sh = pds_pkg::SOURCE_HEIGHT_RESET;
    cfg_dw = pds_pkg::DEST_WIDTH_RESET;
    cfg_dh = pds_pkg::DEST_HEIGHT_RESET;
    restart_stream();
  endfunction

  function automatic void apply_reg(pds_pkg::cfg_write_t w);
    case (w.index)
      pds_pkg::REG_SOURCE_WIDTH:  cfg_sw = w.data;
      pds_pkg::REG_SOURCE_HEIGHT: cfg_sh = w.data;
      pds_pkg::REG_DEST_WIDTH:    cfg_dw = w.data;
      pds_pkg::REG_DEST_HEIGHT:   cfg_dh = w.data;
      default: return;
    endcase
    restart_stream();
  endfunction

  // One accepted item: palette update, or nearest-neighbour pick and step
  function automatic void scale_item(pds_pkg::item_t it);
    logic [10:0] sw, sh, dw, dh;
    logic col_hit, row_hit;
    pds_pkg::result_t r;
    sw = limit_side(cfg_sw, SIDE_LIMIT);
    sh = limit_side(cfg_sh, SIDE_LIMIT);
    dw = limit_side(cfg_dw, sw);
    dh = limit_side(cfg_dh, sh);
    if (it.operation == pds_pkg::OP_WRITE) begin
      palette[it.color_index] = it.entry_rgb;
      return;
    end
    col_hit = (dst_col < dw) && (col_rem < dw);
    row_hit = (dst_row < dh) && (row_rem < dh);
    if (col_hit && row_hit) begin
      r.red       = palette[it.color_index][23:16];
      r.green     = palette[it.color_index][15:8];
      r.blue      = palette[it.color_index][7:0];
      r.out_x     = dst_col[9:0];
      r.out_y     = dst_row[9:0];
      r.frame_end = (dst_col == dw - 11'd1) && (dst_row == dh - 11'd1);
      expected_pixels.push_back(r);
    end
    // column step
    if (col_hit) begin
      dst_col = dst_col + 11'd1;
      col_rem = col_rem + sw;
    end
    col_rem = (col_rem >= dw) ? col_rem - dw : 12'd0;
    src_col = src_col + 11'd1;
    // line end: row step, then frame end
    if (src_col >= sw) begin
      src_col = '0;
      dst_col = '0;
      col_rem = '0;
      if (row_hit) begin
        dst_row = dst_row + 11'd1;
        row_rem = row_rem + sh;
      end
      row_rem = (row_rem >= dh) ? row_rem - dh : 12'd0;
      src_row = src_row + 11'd1;
      if (src_row >= sh) begin
        src_row = '0;
        dst_row = '0;
        row_rem = '0;
      end
    end
  endfunction

  function automatic void compare_field(string name, int unsigned exp, int unsigned act);
    if (exp != act) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
    end
  endfunction

  // Monitor: check output pixels, then track accepted items and registers
  always @(posedge clk) begin : monitor
    pds_pkg::result_t want;
    pds_pkg::result_t got;
    if (!rst) begin
      if (result_ch.valid && result_ch.ready) begin
        got = result_ch.payload;
        pixels_out++;
        if (got.frame_end) frame_ends++;
        if (expected_pixels.size() == 0) begin
          errors++;
          $display("%0t: output pixel with none expected, actual %p", $time, got);
        end else begin
          want = expected_pixels.pop_front();
          compare_field("red", want.red, got.red);
          compare_field("green", want.green, got.green);
          compare_field("blue", want.blue, got.blue);
          compare_field("out_x", want.out_x, got.out_x);
          compare_field("out_y", want.out_y, got.out_y);
          compare_field("frame_end", want.frame_end, got.frame_end);
        end
      end
      if (item_ch.valid && item_ch.ready) begin
        items_in++;
        if (item_ch.payload.operation == pds_pkg::OP_WRITE) writes_in++;
        scale_item(item_ch.payload);
      end
      if (reg_ch.valid && reg_ch.ready) begin
        reg_writes++;
        apply_reg(reg_ch.payload);
      end
    end
  end

  // Sender: bursts of random length, random gaps
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
      item_ch.payload <= '0;
    end else if (!item_ch.valid || item_ch.ready) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        item_ch.valid <= 1'b0;
      end else if (stream_items.size() != 0) begin
        item_ch.valid <= 1'b1;
        item_ch.payload <= stream_items.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        item_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern chosen by rx_cycle[10:8]; one long hold-off
  logic [10:0] rx_cycle = '0;
  int hold_left = 0;
  logic hold_off_done = 1'b0;

  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 11'd1;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (hold_off_req && !hold_off_done) begin
      hold_off_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      result_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      result_ch.ready <= 1'b0;
    end else begin
      case (rx_cycle[10:8])
        3'd0:    result_ch.ready <= 1'b1;
        3'd1:    result_ch.ready <= ($urandom_range(0, 3) != 0);
        3'd2:    result_ch.ready <= ~rx_cycle[2];
        3'd3:    result_ch.ready <= ($urandom_range(0, 1) != 0);
        3'd4:    result_ch.ready <= 1'b1;
        default: result_ch.ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Watchdog on cycles with no transfer anywhere
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (reg_ch.valid && reg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic void push_item(logic op, logic [7:0] idx, logic [23:0] rgb);
    pds_pkg::item_t it;
    it.operation = op;
    it.color_index = idx;
    it.entry_rgb = rgb;
    stream_items.push_back(it);
  endfunction

  function automatic void push_random(int n, int write_share);
    for (int i = 0; i < n; i++) begin
      push_item(($urandom_range(0, 99) < write_share) ? pds_pkg::OP_WRITE : pds_pkg::OP_PIXEL,
                8'($urandom_range(0, 255)), 24'($urandom));
    end
  endfunction

  function automatic logic [10:0] pick_side();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 11'd0;
    if (r == 1) return 11'h7FF;
    if (r == 2) return 11'd1024;
    return 11'($urandom_range(1, 12));
  endfunction

  task automatic write_reg(logic [pds_pkg::REG_IDX_W-1:0] idx,
                           logic [pds_pkg::CFG_W-1:0] val);
    @(posedge clk);
    reg_ch.valid <= 1'b1;
    reg_ch.payload <= {idx, val};
    do @(posedge clk); while (!reg_ch.ready);
    reg_ch.valid <= 1'b0;
  endtask

  // Wait until every item is taken and every pixel out, then cover latency
  task automatic wait_idle();
    @(negedge clk);
    while (stream_items.size() != 0 || item_ch.valid || expected_pixels.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_sizes(logic [10:0] sw, logic [10:0] sh, logic [10:0] dw,
                           logic [10:0] dh);
    write_reg(pds_pkg::REG_SOURCE_WIDTH, sw);
    write_reg(pds_pkg::REG_SOURCE_HEIGHT, sh);
    write_reg(pds_pkg::REG_DEST_WIDTH, dw);
    write_reg(pds_pkg::REG_DEST_HEIGHT, dh);
    @(negedge clk);
  endtask

  initial begin
    logic [3:0] mask;
    rst = 1'b1;
    reset_scaler();
    reg_ch.valid <= 1'b0;
    reg_ch.payload <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset sizes and grey ramp; palette writes in between must not advance
    push_item(pds_pkg::OP_PIXEL, 8'h00, 24'hFFFFFF);
    push_item(pds_pkg::OP_PIXEL, 8'hFF, 24'h000000);
    push_item(pds_pkg::OP_PIXEL, 8'h80, 24'h000000);
    push_item(pds_pkg::OP_PIXEL, 8'h7F, 24'hFFFFFF);
    push_item(pds_pkg::OP_WRITE, 8'h00, 24'hFFFFFF);
    push_item(pds_pkg::OP_WRITE, 8'hFF, 24'h000000);
    push_item(pds_pkg::OP_WRITE, 8'h80, 24'hA5A5A5);
    push_item(pds_pkg::OP_WRITE, 8'h7F, 24'h5A5A5A);
    push_item(pds_pkg::OP_PIXEL, 8'h00, 24'h000000);
    push_item(pds_pkg::OP_PIXEL, 8'hFF, 24'h000000);
    push_item(pds_pkg::OP_PIXEL, 8'h80, 24'h000000);
    push_item(pds_pkg::OP_PIXEL, 8'h7F, 24'h000000);
    push_item(pds_pkg::OP_WRITE, 8'h00, 24'h000000);
    push_item(pds_pkg::OP_PIXEL, 8'h00, 24'h000000);
    push_item(pds_pkg::OP_PIXEL, 8'h01, 24'h000000);
    wait_idle();

    // All sizes zero: clamp to 1x1, every pixel is a whole frame
    set_sizes(11'd0, 11'd0, 11'd0, 11'd0);
    push_item(pds_pkg::OP_PIXEL, 8'hFF, 24'h000000);
    push_item(pds_pkg::OP_PIXEL, 8'h80, 24'h000000);
    push_item(pds_pkg::OP_WRITE, 8'hFF, 24'h010203);
    push_item(pds_pkg::OP_PIXEL, 8'hFF, 24'h000000);
    push_item(pds_pkg::OP_PIXEL, 8'h00, 24'h000000);
    wait_idle();

    // Widest line, oversize registers clamped; receiver holds off meanwhile
    set_sizes(11'h7FF, 11'd1, 11'h7FF, 11'd0);
    push_random(1050, 5);
    hold_off_req = 1'b1;
    wait_idle();

    // Tallest frame, one column
    set_sizes(11'd1, 11'd1024, 11'd0, 11'd1024);
    push_random(260, 5);
    wait_idle();

    // Random small sizes, each phase restarts the stream part way through
    for (int ph = 0; ph < 16; ph++) begin
      mask = 4'($urandom_range(1, 15));
      if (mask[0]) write_reg(pds_pkg::REG_SOURCE_WIDTH, pick_side());
      if (mask[1]) write_reg(pds_pkg::REG_SOURCE_HEIGHT, pick_side());
      if (mask[2]) write_reg(pds_pkg::REG_DEST_WIDTH, pick_side());
      if (mask[3]) write_reg(pds_pkg::REG_DEST_HEIGHT, pick_side());
      @(negedge clk);
      push_random($urandom_range(10, 30), 15);
      if (ph % 8 == 3) begin
        // unused register index: no effect, stream keeps its place
        wait_idle();
        write_reg(REG_UNUSED, 11'($urandom));
        @(negedge clk);
        push_random($urandom_range(10, 20), 10);
      end
      wait_idle();
    end

    if (expected_pixels.size() != 0) begin
      errors++;
      $display("%0t: %0d output pixels never arrived", $time, expected_pixels.size());
    end
    $display("Run covered %0d items (%0d palette writes) and %0d register writes,",
             items_in, writes_in, reg_writes);
    $display("with %0d output pixels checked, %0d of them frame ends.",
             pixels_out, frame_ends);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
